// ----- rtl/core/sine_pwm_inverter_controller_core_macros.svh -----
// Assertion macros for the sine PWM inverter controller core.
// Included by the top level. No other dependencies.
`ifndef SINE_PWM_INVERTER_CONTROLLER_CORE_MACROS_SVH
`define SINE_PWM_INVERTER_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low
`define SPIC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spic: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define SPIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spic: next-cycle check failed");
`else
`define SPIC_ASSERT_IMPLY(label, ante, cons)
`define SPIC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/spic_pkg.sv -----
// Shared types, constants, microcode program and constant tables of the
// sine PWM inverter controller core. No dependencies.
`timescale 1ns / 1ps

package spic_pkg;

    // Sizes
    localparam int unsigned TABLE_DEPTH  = 128;
    localparam int unsigned BLINK_PERIOD = 4096;
    localparam int unsigned FULL_SCALE   = 248;

    localparam int unsigned PHASE_W  = 32;
    localparam int unsigned IDX_W    = $clog2(TABLE_DEPTH);
    localparam int unsigned BLINK_W  = $clog2(BLINK_PERIOD + 1);
    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned LEVEL_W  = 7;
    localparam int unsigned AMP_W    = 7;
    localparam int unsigned OFFSET_W = 8;
    localparam int unsigned DEAD_W   = 3;
    localparam int unsigned CMP_W    = 8;
    localparam int unsigned SCALE_W  = 8;
    localparam int unsigned Q_FRAC   = 30;
    localparam int unsigned SINE_W   = Q_FRAC + 1;
    localparam int unsigned PROD_W   = SCALE_W + SINE_W;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned FAULT_W  = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Fixed-point constants of the sine generator
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam int unsigned TAYLOR_TERMS = 8;
    localparam int unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210, 272};

    // Register reset values
    localparam logic [PHASE_W-1:0]  PHASE_INC_RESET = 32'd9126965;
    localparam logic [DEAD_W-1:0]   DEAD_RESET      = 3'd6;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET    = 8'd160;
    localparam logic [AMP_W-1:0]    AMP_MIN_RESET   = 7'd80;
    localparam logic [AMP_W-1:0]    AMP_MAX_RESET   = 7'd100;
    localparam logic [SAMPLE_W-1:0] LOST_AC_RESET   = 10'd32;
    localparam logic [AMP_W-1:0]    AMP_RESET       = 7'd80;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INCREMENT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGULATION_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_AC_LEVEL     = 3'd5;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVERLOAD = 2'd2;

    // Fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE     = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_LOST_AC  = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_OVERLOAD = 2'd2;

    // Sink leg switching indexes
    localparam logic [IDX_W-1:0] IDX_SINK_ONE_LOW  = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_SINK_TWO_HIGH = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_SINK_TWO_LOW  = IDX_W'(TABLE_DEPTH / 2 + 1);
    localparam logic [IDX_W-1:0] IDX_SINK_ONE_HIGH = IDX_W'(TABLE_DEPTH / 2 + 2);
    localparam logic [BLINK_W-1:0] BLINK_LAST = BLINK_W'(BLINK_PERIOD);

    // Microcode
    typedef enum logic [2:0] {
        OP_NONE,
        OP_FETCH,
        OP_ADVANCE,
        OP_TICK,
        OP_REGULATE,
        OP_OVERLOAD,
        OP_LOOKUP,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_WORD,
        COND_OUT_BUSY,
        COND_NOT_TICK,
        COND_NOT_SAMPLE
    } cond_t;

    localparam int unsigned UCODE_LEN = 9;
    localparam int unsigned STEP_W    = $clog2(UCODE_LEN);
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_FETCH    = STEP_W'(0);
    localparam step_t STEP_DISPATCH = STEP_W'(1);
    localparam step_t STEP_ADVANCE  = STEP_W'(2);
    localparam step_t STEP_TICK     = STEP_W'(3);
    localparam step_t STEP_BRANCH   = STEP_W'(4);
    localparam step_t STEP_REGULATE = STEP_W'(5);
    localparam step_t STEP_OVERLOAD = STEP_W'(6);
    localparam step_t STEP_LOOKUP   = STEP_W'(7);
    localparam step_t STEP_EMIT     = STEP_W'(8);

    // hold: stay on this step, op suppressed; jump: go to target instead of step+1
    typedef struct packed {
        op_t   op;
        cond_t hold;
        cond_t jump;
        step_t target;
    } ucode_t;

    localparam ucode_t UCODE [UCODE_LEN] = '{
        '{OP_FETCH,    COND_NO_WORD,  COND_NEVER,      STEP_FETCH},
        '{OP_NONE,     COND_NEVER,    COND_NOT_TICK,   STEP_BRANCH},
        '{OP_ADVANCE,  COND_NEVER,    COND_NEVER,      STEP_FETCH},
        '{OP_TICK,     COND_NEVER,    COND_ALWAYS,     STEP_LOOKUP},
        '{OP_NONE,     COND_NEVER,    COND_NOT_SAMPLE, STEP_OVERLOAD},
        '{OP_REGULATE, COND_NEVER,    COND_ALWAYS,     STEP_LOOKUP},
        '{OP_OVERLOAD, COND_NEVER,    COND_NEVER,      STEP_FETCH},
        '{OP_LOOKUP,   COND_NEVER,    COND_NEVER,      STEP_FETCH},
        '{OP_EMIT,     COND_OUT_BUSY, COND_ALWAYS,     STEP_FETCH}
    };

    // Sine magnitude table, Q30, built at elaboration from a truncated series
    typedef logic [SINE_W-1:0] sine_rom_t [TABLE_DEPTH];
    typedef logic [SCALE_W-1:0] scale_rom_t [2**AMP_W];

    function automatic logic [SINE_W-1:0] sine_mag_q30(input int unsigned k);
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        m = (64'(k) * 64'd2) % TABLE_DEPTH;
        if (64'd2 * m > 64'(TABLE_DEPTH))
            m = 64'(TABLE_DEPTH) - m;
        if (m == 64'd0)
            return '0;
        if (64'd2 * m == 64'(TABLE_DEPTH))
            return SINE_W'(ONE_Q30);
        x    = (PI_Q30 * m) / TABLE_DEPTH;
        x2   = (x * x) >> Q_FRAC;
        term = x;
        sum  = x;
        for (int unsigned n = 1; n <= TAYLOR_TERMS; n++)
        begin
            term = ((term * x2) >> Q_FRAC) / TAYLOR_DIV[n-1];
            if (n % 2 == 1)
                sum = (sum >= term) ? sum - term : 64'd0;
            else
                sum = sum + term;
        end
        if (sum > ONE_Q30)
            sum = ONE_Q30;
        return SINE_W'(sum);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int unsigned k = 0; k < TABLE_DEPTH; k++)
        begin
            rom[k] = sine_mag_q30(k);
        end
        return rom;
    endfunction

    // Amplitude percent to scale, saturating at the compare range
    function automatic scale_rom_t build_scale_rom();
        scale_rom_t rom;
        int unsigned s;
        for (int unsigned a = 0; a < 2**AMP_W; a++)
        begin
            s = (FULL_SCALE * a) / 100;
            rom[a] = (s > 255) ? SCALE_W'(255) : SCALE_W'(s);
        end
        return rom;
    endfunction

    localparam sine_rom_t  SINE_ROM  = build_sine_rom();
    localparam scale_rom_t SCALE_ROM = build_scale_rom();

endpackage

// ----- rtl/core/spic_if.sv -----
// Channel interfaces of the sine PWM inverter controller core: input items,
// result words and configuration writes. Depends on spic_pkg.
`timescale 1ns / 1ps

interface spic_in_if;
    logic                               valid;
    logic                               ready;
    logic [spic_pkg::KIND_W-1:0]        kind;
    logic [spic_pkg::SAMPLE_W-1:0]      sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink (input valid, input kind, input sample, output ready);
endinterface

interface spic_out_if;
    logic                               valid;
    logic                               ready;
    logic [spic_pkg::CMP_W-1:0]         high_compare;
    logic [spic_pkg::CMP_W-1:0]         low_compare;
    logic                               sink_one;
    logic                               sink_two;
    logic                               status_led;
    logic                               drive_enable;
    logic [spic_pkg::AMP_W-1:0]         amplitude_now;
    logic [spic_pkg::FAULT_W-1:0]       fault_code;

    modport source (
        output valid, output high_compare, output low_compare, output sink_one,
        output sink_two, output status_led, output drive_enable,
        output amplitude_now, output fault_code, input ready
    );
    modport sink (
        input valid, input high_compare, input low_compare, input sink_one,
        input sink_two, input status_led, input drive_enable,
        input amplitude_now, input fault_code, output ready
    );
endinterface

interface spic_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [spic_pkg::CFG_IDX_W-1:0]     index;
    logic [spic_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/sine_pwm_inverter_controller_core.sv -----
// Top level of the sine PWM inverter controller core: microcode sequencer
// and datapath. Depends on spic_pkg, spic_if.sv and the macros header.
`timescale 1ns / 1ps
`include "sine_pwm_inverter_controller_core_macros.svh"

// Sine PWM inverter controller core.
// Channels: item (sink) takes one word per event: kind 0 PWM tick, 1 output
// voltage sample, 2 overload, 3 no effect. result (source) returns one word
// per item with both compare values, sink leg levels, LED, drive enable,
// amplitude and fault code. cfg (sink) writes one register per handshake;
// it is always ready. It must be written only while the core is idle; the
// core itself does not enforce this. Sequence: a small microcode program
// runs each item through fetch, dispatch, two event steps, table lookup and
// emit, one control word per cycle unless fetch waits for an item or emit
// waits for the result side. The result word is registered by the emit step,
// and the next item is taken only once emit returns to fetch. The sine and
// scale tables are constant logic, the compare value is one 8 x 31 multiply in the lookup step.
// Reset: rst_n clears the sequencer to fetch, loads the register defaults,
// zeroes the phase, blink counter and sinks, arms the first drive enable and
// sets the amplitude to 80 percent. No clearing pass is needed.
// Stall: while result.ready is low and a word is pending, one more item is
// taken and runs up to the emit step, where it holds; no further item is
// accepted until the pending word is taken.
module sine_pwm_inverter_controller_core (
    input  logic            clk,
    input  logic            rst_n,
    spic_cfg_if.sink        cfg,
    spic_in_if.sink         item,
    spic_out_if.source      result
);

    // Configuration registers
    logic [spic_pkg::PHASE_W-1:0]   phase_inc_reg, phase_inc_next;
    logic [spic_pkg::DEAD_W-1:0]    dead_reg, dead_next;
    logic [spic_pkg::OFFSET_W-1:0]  offset_reg, offset_next;
    logic [spic_pkg::AMP_W-1:0]     amp_min_reg, amp_min_next;
    logic [spic_pkg::AMP_W-1:0]     amp_max_reg, amp_max_next;
    logic [spic_pkg::SAMPLE_W-1:0]  lost_ac_reg, lost_ac_next;

    // Sequencer
    spic_pkg::step_t                step_reg, step_next;
    spic_pkg::ucode_t               uword;
    logic                           hold_c;
    logic                           jump_c;

    // Captured item
    logic [spic_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [spic_pkg::SAMPLE_W-1:0]  sample_reg, sample_next;

    // Controller state
    logic [spic_pkg::PHASE_W-1:0]   phase_reg, phase_next;
    logic [spic_pkg::BLINK_W-1:0]   blink_reg, blink_next;
    logic                           led_reg, led_next;
    logic                           enable_pending_reg, enable_pending_next;
    logic                           drive_on_reg, drive_on_next;
    logic                           sink_one_reg, sink_one_next;
    logic                           sink_two_reg, sink_two_next;
    logic [spic_pkg::AMP_W-1:0]     amp_reg, amp_next;
    logic [spic_pkg::LEVEL_W-1:0]   last_level_reg, last_level_next;
    logic [spic_pkg::FAULT_W-1:0]   fault_reg, fault_next;
    logic [spic_pkg::PROD_W-1:0]    prod_reg, prod_next;

    // Result word
    logic                           out_valid_reg, out_valid_next;
    logic [spic_pkg::CMP_W-1:0]     out_high_reg, out_high_next;
    logic [spic_pkg::CMP_W-1:0]     out_low_reg, out_low_next;
    logic                           out_sink_one_reg, out_sink_one_next;
    logic                           out_sink_two_reg, out_sink_two_next;
    logic                           out_led_reg, out_led_next;
    logic                           out_drive_reg, out_drive_next;
    logic [spic_pkg::AMP_W-1:0]     out_amp_reg, out_amp_next;
    logic [spic_pkg::FAULT_W-1:0]   out_fault_reg, out_fault_next;

    // Datapath helpers
    logic [spic_pkg::IDX_W-1:0]     index_c;
    logic [spic_pkg::LEVEL_W-1:0]   level_c;
    logic [spic_pkg::OFFSET_W-1:0]  target_c;
    logic [spic_pkg::CMP_W-1:0]     low_c;
    logic [spic_pkg::CMP_W:0]       high_sum_c;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        phase_inc_next = phase_inc_reg;
        dead_next      = dead_reg;
        offset_next    = offset_reg;
        amp_min_next   = amp_min_reg;
        amp_max_next   = amp_max_reg;
        lost_ac_next   = lost_ac_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                spic_pkg::CFG_PHASE_INCREMENT:   phase_inc_next = cfg.data;
                spic_pkg::CFG_DEAD_TIME:         dead_next = cfg.data[spic_pkg::DEAD_W-1:0];
                spic_pkg::CFG_REGULATION_OFFSET: offset_next = cfg.data[spic_pkg::OFFSET_W-1:0];
                spic_pkg::CFG_AMPLITUDE_MIN:     amp_min_next = cfg.data[spic_pkg::AMP_W-1:0];
                spic_pkg::CFG_AMPLITUDE_MAX:     amp_max_next = cfg.data[spic_pkg::AMP_W-1:0];
                spic_pkg::CFG_LOST_AC_LEVEL:     lost_ac_next = cfg.data[spic_pkg::SAMPLE_W-1:0];
                default:                         phase_inc_next = phase_inc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg <= spic_pkg::PHASE_INC_RESET;
            dead_reg      <= spic_pkg::DEAD_RESET;
            offset_reg    <= spic_pkg::OFFSET_RESET;
            amp_min_reg   <= spic_pkg::AMP_MIN_RESET;
            amp_max_reg   <= spic_pkg::AMP_MAX_RESET;
            lost_ac_reg   <= spic_pkg::LOST_AC_RESET;
        end
        else
        begin
            phase_inc_reg <= phase_inc_next;
            dead_reg      <= dead_next;
            offset_reg    <= offset_next;
            amp_min_reg   <= amp_min_next;
            amp_max_reg   <= amp_max_next;
            lost_ac_reg   <= lost_ac_next;
        end
    end

    // Decode the control word and its conditions
    assign uword = spic_pkg::UCODE[step_reg];

    function automatic logic eval_cond(
        input spic_pkg::cond_t          c,
        input logic                     in_valid,
        input logic                     out_busy,
        input logic [spic_pkg::KIND_W-1:0] kind
    );
        logic r;
        case (c)
            spic_pkg::COND_NEVER:      r = 1'b0;
            spic_pkg::COND_ALWAYS:     r = 1'b1;
            spic_pkg::COND_NO_WORD:    r = !in_valid;
            spic_pkg::COND_OUT_BUSY:   r = out_busy;
            spic_pkg::COND_NOT_TICK:   r = (kind != spic_pkg::KIND_TICK);
            spic_pkg::COND_NOT_SAMPLE: r = (kind != spic_pkg::KIND_SAMPLE);
            default:                   r = 1'b0;
        endcase
        return r;
    endfunction

    assign hold_c = eval_cond(uword.hold, item.valid, out_valid_reg && !result.ready, kind_reg);
    assign jump_c = eval_cond(uword.jump, item.valid, out_valid_reg && !result.ready, kind_reg);

    // Advance the step counter
    always_comb
    begin
        if (hold_c)
            step_next = step_reg;
        else if (jump_c)
            step_next = uword.target;
        else
            step_next = step_reg + spic_pkg::STEP_W'(1);
    end

    assign item.ready = (uword.op == spic_pkg::OP_FETCH);

    // Table index, sample level, regulation target, compare values
    assign index_c = phase_reg[spic_pkg::PHASE_W-1 -: spic_pkg::IDX_W];
    assign level_c = sample_reg[spic_pkg::SAMPLE_W-1 -: spic_pkg::LEVEL_W];
    assign low_c   = prod_reg[spic_pkg::Q_FRAC +: spic_pkg::CMP_W];
    assign high_sum_c = {1'b0, low_c} + (spic_pkg::CMP_W + 1)'(dead_reg);

    always_comb
    begin
        if (offset_reg < {1'b0, level_c})
            target_c = {1'b0, amp_max_reg};
        else
            target_c = offset_reg - {1'b0, level_c};
        if (target_c >= {1'b0, amp_max_reg})
            target_c = {1'b0, amp_max_reg};
        if (target_c <= {1'b0, amp_min_reg})
            target_c = {1'b0, amp_min_reg};
    end

    // Execute the control word
    always_comb
    begin
        kind_next           = kind_reg;
        sample_next         = sample_reg;
        phase_next          = phase_reg;
        blink_next          = blink_reg;
        led_next            = led_reg;
        enable_pending_next = enable_pending_reg;
        drive_on_next       = drive_on_reg;
        sink_one_next       = sink_one_reg;
        sink_two_next       = sink_two_reg;
        amp_next            = amp_reg;
        last_level_next     = last_level_reg;
        fault_next          = fault_reg;
        prod_next           = prod_reg;
        out_valid_next      = out_valid_reg && !result.ready;
        out_high_next       = out_high_reg;
        out_low_next        = out_low_reg;
        out_sink_one_next   = out_sink_one_reg;
        out_sink_two_next   = out_sink_two_reg;
        out_led_next        = out_led_reg;
        out_drive_next      = out_drive_reg;
        out_amp_next        = out_amp_reg;
        out_fault_next      = out_fault_reg;

        if (!hold_c)
        begin
            case (uword.op)
                spic_pkg::OP_FETCH:
                begin
                    kind_next   = item.kind;
                    sample_next = item.sample;
                end
                spic_pkg::OP_ADVANCE:
                begin
                    if (fault_reg != spic_pkg::FAULT_OVERLOAD)
                        phase_next = phase_reg + phase_inc_reg;
                end
                spic_pkg::OP_TICK:
                begin
                    if (fault_reg != spic_pkg::FAULT_OVERLOAD)
                    begin
                        // Switch the sink legs at their phases
                        if (index_c == spic_pkg::IDX_SINK_ONE_LOW)
                            sink_one_next = 1'b0;
                        else if (index_c == spic_pkg::IDX_SINK_TWO_HIGH)
                            sink_two_next = 1'b1;
                        else if (index_c == spic_pkg::IDX_SINK_TWO_LOW)
                            sink_two_next = 1'b0;
                        else if (index_c == spic_pkg::IDX_SINK_ONE_HIGH)
                            sink_one_next = 1'b1;
                        // Blink and first-pass enable
                        if (blink_reg == spic_pkg::BLINK_LAST)
                        begin
                            blink_next = '0;
                            led_next   = !led_reg;
                            if (enable_pending_reg && fault_reg == spic_pkg::FAULT_NONE)
                            begin
                                drive_on_next       = 1'b1;
                                enable_pending_next = 1'b0;
                            end
                        end
                        else
                        begin
                            blink_next = blink_reg + spic_pkg::BLINK_W'(1);
                        end
                    end
                end
                spic_pkg::OP_REGULATE:
                begin
                    if (fault_reg == spic_pkg::FAULT_NONE)
                    begin
                        if (level_c != last_level_reg)
                        begin
                            amp_next        = target_c[spic_pkg::AMP_W-1:0];
                            last_level_next = level_c;
                        end
                        if (sample_reg <= lost_ac_reg)
                        begin
                            fault_next          = spic_pkg::FAULT_LOST_AC;
                            drive_on_next       = 1'b0;
                            enable_pending_next = 1'b0;
                        end
                    end
                end
                spic_pkg::OP_OVERLOAD:
                begin
                    if (kind_reg == spic_pkg::KIND_OVERLOAD)
                    begin
                        if (fault_reg == spic_pkg::FAULT_NONE)
                            fault_next = spic_pkg::FAULT_OVERLOAD;
                        drive_on_next       = 1'b0;
                        enable_pending_next = 1'b0;
                    end
                end
                spic_pkg::OP_LOOKUP:
                begin
                    prod_next = spic_pkg::PROD_W'(spic_pkg::SCALE_ROM[amp_reg])
                              * spic_pkg::PROD_W'(spic_pkg::SINE_ROM[index_c]);
                end
                spic_pkg::OP_EMIT:
                begin
                    out_valid_next    = 1'b1;
                    out_low_next      = low_c;
                    out_high_next     = high_sum_c[spic_pkg::CMP_W]
                                      ? {spic_pkg::CMP_W{1'b1}}
                                      : high_sum_c[spic_pkg::CMP_W-1:0];
                    out_sink_one_next = sink_one_reg;
                    out_sink_two_next = sink_two_reg;
                    out_led_next      = led_reg;
                    out_drive_next    = drive_on_reg;
                    out_amp_next      = amp_reg;
                    out_fault_next    = fault_reg;
                end
                default:
                begin
                    prod_next = prod_reg;
                end
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg           <= spic_pkg::STEP_FETCH;
            phase_reg          <= '0;
            blink_reg          <= '0;
            led_reg            <= 1'b0;
            enable_pending_reg <= 1'b1;
            drive_on_reg       <= 1'b0;
            sink_one_reg       <= 1'b0;
            sink_two_reg       <= 1'b0;
            amp_reg            <= spic_pkg::AMP_RESET;
            last_level_reg     <= '0;
            fault_reg          <= spic_pkg::FAULT_NONE;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            step_reg           <= step_next;
            phase_reg          <= phase_next;
            blink_reg          <= blink_next;
            led_reg            <= led_next;
            enable_pending_reg <= enable_pending_next;
            drive_on_reg       <= drive_on_next;
            sink_one_reg       <= sink_one_next;
            sink_two_reg       <= sink_two_next;
            amp_reg            <= amp_next;
            last_level_reg     <= last_level_next;
            fault_reg          <= fault_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg         <= kind_next;
        sample_reg       <= sample_next;
        prod_reg         <= prod_next;
        out_high_reg     <= out_high_next;
        out_low_reg      <= out_low_next;
        out_sink_one_reg <= out_sink_one_next;
        out_sink_two_reg <= out_sink_two_next;
        out_led_reg      <= out_led_next;
        out_drive_reg    <= out_drive_next;
        out_amp_reg      <= out_amp_next;
        out_fault_reg    <= out_fault_next;
    end

    // Drive the result channel
    assign result.valid         = out_valid_reg;
    assign result.high_compare  = out_high_reg;
    assign result.low_compare   = out_low_reg;
    assign result.sink_one      = out_sink_one_reg;
    assign result.sink_two      = out_sink_two_reg;
    assign result.status_led    = out_led_reg;
    assign result.drive_enable  = out_drive_reg;
    assign result.amplitude_now = out_amp_reg;
    assign result.fault_code    = out_fault_reg;

    // Checks
    `SPIC_ASSERT_IMPLY(a_fault_blocks_drive, fault_reg != spic_pkg::FAULT_NONE, !drive_on_reg && !enable_pending_reg)
    `SPIC_ASSERT_NEXT(a_fault_sticky, fault_reg != spic_pkg::FAULT_NONE, fault_reg == $past(fault_reg))
    `SPIC_ASSERT_IMPLY(a_load_from_emit, $rose(out_valid_reg), $past(step_reg) == spic_pkg::STEP_EMIT)

endmodule

// ----- test/tb_sine_pwm_inverter_controller_core.sv -----
// Self-checking bench for sine_pwm_inverter_controller_core: directed and random
// ticks, voltage samples and faults, checked against a cycle-free predictor.
// Depends on spic_pkg, spic_if.sv and the core RTL.
`timescale 1ns / 1ps

module tb_sine_pwm_inverter_controller_core;

    // Kind with no effect on the controller
    localparam logic [spic_pkg::KIND_W-1:0] KIND_NOP = 2'd3;

    typedef struct {
        logic [spic_pkg::CMP_W-1:0]   high_compare;
        logic [spic_pkg::CMP_W-1:0]   low_compare;
        logic                         sink_one;
        logic                         sink_two;
        logic                         status_led;
        logic                         drive_enable;
        logic [spic_pkg::AMP_W-1:0]   amplitude_now;
        logic [spic_pkg::FAULT_W-1:0] fault_code;
    } pwm_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    spic_cfg_if cfg_if();
    spic_in_if  item_if();
    spic_out_if result_if();

    sine_pwm_inverter_controller_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .item   (item_if),
        .result (result_if)
    );

    // Shadow registers
    logic [spic_pkg::PHASE_W-1:0]  cfg_phase_step;
    logic [spic_pkg::DEAD_W-1:0]   cfg_dead_time;
    logic [spic_pkg::OFFSET_W-1:0] cfg_offset;
    logic [spic_pkg::AMP_W-1:0]    cfg_amp_floor;
    logic [spic_pkg::AMP_W-1:0]    cfg_amp_ceiling;
    logic [spic_pkg::SAMPLE_W-1:0] cfg_lost_ac;

    // Shadow controller state
    logic [spic_pkg::PHASE_W-1:0]  phase_acc;
    int unsigned                   blink_count;
    logic                          led_on;
    logic                          drive_armed;
    logic                          drive_live;
    logic                          leg_one;
    logic                          leg_two;
    logic [spic_pkg::AMP_W-1:0]    amp_pct;
    logic [spic_pkg::LEVEL_W-1:0]  prev_level;
    logic [spic_pkg::FAULT_W-1:0]  fault_now;

    pwm_word_t pending_pwm_words[$];
    int        mismatch_count = 0;
    int        hold_request = 0;
    bit        no_idle = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Sine magnitude in Q30, angle folded to the first quadrant
    function automatic longint unsigned sine_magnitude_q30(input int unsigned slot);
        longint unsigned span;
        longint unsigned m;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned total;
        span = spic_pkg::TABLE_DEPTH;
        m = (64'(slot) * 2) % span;
        if (2 * m > span)
            m = span - m;
        if (m == 0)
            return 0;
        if (2 * m == span)
            return spic_pkg::ONE_Q30;
        x = (spic_pkg::PI_Q30 * m) / span;
        x2 = (x * x) >> spic_pkg::Q_FRAC;
        term = x;
        total = x;
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> spic_pkg::Q_FRAC) / 64'(4 * n * n + 2 * n);
            if (n % 2 == 1)
                total = (total >= term) ? total - term : 0;
            else
                total = total + term;
        end
        return (total > spic_pkg::ONE_Q30) ? spic_pkg::ONE_Q30 : total;
    endfunction

    function automatic int unsigned table_slot();
        return 32'((64'(phase_acc) * spic_pkg::TABLE_DEPTH) >> spic_pkg::PHASE_W);
    endfunction

    // Keep the first fault code, drop the drive
    function automatic void latch_fault(input logic [spic_pkg::FAULT_W-1:0] code);
        if (fault_now == spic_pkg::FAULT_NONE)
            fault_now = code;
        drive_live = 1'b0;
        drive_armed = 1'b0;
    endfunction

    // Advance the shadow controller by one event and build its result word
    function automatic pwm_word_t predict_pwm_word(
        input logic [spic_pkg::KIND_W-1:0]   kind,
        input logic [spic_pkg::SAMPLE_W-1:0] reading
    );
        pwm_word_t w;
        int unsigned slot;
        logic [spic_pkg::LEVEL_W-1:0] level;
        int unsigned target;
        longint unsigned scale;
        longint unsigned low;
        longint unsigned high;
        if (kind == spic_pkg::KIND_TICK)
        begin
            if (fault_now != spic_pkg::FAULT_OVERLOAD)
            begin
                phase_acc = phase_acc + cfg_phase_step;
                slot = table_slot();
                if (slot == spic_pkg::IDX_SINK_ONE_LOW)
                    leg_one = 1'b0;
                else if (slot == spic_pkg::IDX_SINK_TWO_HIGH)
                    leg_two = 1'b1;
                else if (slot == spic_pkg::IDX_SINK_TWO_LOW)
                    leg_two = 1'b0;
                else if (slot == spic_pkg::IDX_SINK_ONE_HIGH)
                    leg_one = 1'b1;
                if (blink_count == spic_pkg::BLINK_PERIOD)
                begin
                    blink_count = 0;
                    led_on = ~led_on;
                    if (drive_armed && fault_now == spic_pkg::FAULT_NONE)
                    begin
                        drive_live = 1'b1;
                        drive_armed = 1'b0;
                    end
                end
                else
                begin
                    blink_count++;
                end
            end
        end
        else if (kind == spic_pkg::KIND_SAMPLE)
        begin
            if (fault_now == spic_pkg::FAULT_NONE)
            begin
                level = spic_pkg::LEVEL_W'(reading >> 3);
                if (cfg_offset < level)
                    target = 32'(cfg_amp_ceiling);
                else
                    target = 32'(cfg_offset - level);
                if (target >= cfg_amp_ceiling)
                    target = 32'(cfg_amp_ceiling);
                if (target <= cfg_amp_floor)
                    target = 32'(cfg_amp_floor);
                if (level != prev_level)
                begin
                    amp_pct = spic_pkg::AMP_W'(target);
                    prev_level = level;
                end
                if (reading <= cfg_lost_ac)
                    latch_fault(spic_pkg::FAULT_LOST_AC);
            end
        end
        else if (kind == spic_pkg::KIND_OVERLOAD)
        begin
            latch_fault(spic_pkg::FAULT_OVERLOAD);
        end

        // Compare values follow the current phase and amplitude on every event
        scale = (spic_pkg::FULL_SCALE * amp_pct) / 100;
        if (scale > 255)
            scale = 255;
        low = ((scale * sine_magnitude_q30(table_slot())) >> spic_pkg::Q_FRAC) & 8'hFF;
        high = low + cfg_dead_time;
        if (high > 255)
            high = 255;
        w.high_compare  = spic_pkg::CMP_W'(high);
        w.low_compare   = spic_pkg::CMP_W'(low);
        w.sink_one      = leg_one;
        w.sink_two      = leg_two;
        w.status_led    = led_on;
        w.drive_enable  = drive_live;
        w.amplitude_now = amp_pct;
        w.fault_code    = fault_now;
        return w;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Match one accepted result word against the oldest prediction
    task automatic check_pwm_word();
        pwm_word_t want;
        if (pending_pwm_words.size() == 0)
        begin
            $error("result word arrived with no prediction pending");
            mismatch_count++;
        end
        else
        begin
            want = pending_pwm_words.pop_front();
            compare_field("high_compare", 32'(want.high_compare),
                          32'(result_if.high_compare));
            compare_field("low_compare", 32'(want.low_compare),
                          32'(result_if.low_compare));
            compare_field("sink_one", 32'(want.sink_one), 32'(result_if.sink_one));
            compare_field("sink_two", 32'(want.sink_two), 32'(result_if.sink_two));
            compare_field("status_led", 32'(want.status_led), 32'(result_if.status_led));
            compare_field("drive_enable", 32'(want.drive_enable),
                          32'(result_if.drive_enable));
            compare_field("amplitude_now", 32'(want.amplitude_now),
                          32'(result_if.amplitude_now));
            compare_field("fault_code", 32'(want.fault_code), 32'(result_if.fault_code));
        end
    endtask

    // Take result words; stall at random or for a requested hold-off
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
                check_pwm_word();
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 99) < 12)
            begin
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Offer one event word, predict it, and hold until it is accepted
    task automatic send_event(input logic [spic_pkg::KIND_W-1:0] kind,
                              input logic [spic_pkg::SAMPLE_W-1:0] reading);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 12)
            gap = $urandom_range(1, 8);
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid  <= 1'b1;
        item_if.kind   <= kind;
        item_if.sample <= reading;
        pending_pwm_words.push_back(predict_pwm_word(kind, reading));
        do @(posedge clk); while (!item_if.ready);
    endtask

    // Drop valid after the last word of a burst
    task automatic park_item();
        item_if.valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        do @(posedge clk); while (pending_pwm_words.size() != 0);
    endtask

    // Write all six registers back to back; only called while the core is idle
    task automatic program_registers(input logic [spic_pkg::PHASE_W-1:0] step,
                                     input logic [spic_pkg::DEAD_W-1:0] dead,
                                     input logic [spic_pkg::OFFSET_W-1:0] offset,
                                     input logic [spic_pkg::AMP_W-1:0] amp_floor,
                                     input logic [spic_pkg::AMP_W-1:0] amp_ceiling,
                                     input logic [spic_pkg::SAMPLE_W-1:0] lost_ac);
        logic [spic_pkg::CFG_IDX_W-1:0]  regs [6];
        logic [spic_pkg::CFG_DATA_W-1:0] values [6];
        regs = '{spic_pkg::CFG_PHASE_INCREMENT, spic_pkg::CFG_DEAD_TIME,
                 spic_pkg::CFG_REGULATION_OFFSET, spic_pkg::CFG_AMPLITUDE_MIN,
                 spic_pkg::CFG_AMPLITUDE_MAX, spic_pkg::CFG_LOST_AC_LEVEL};
        values = '{spic_pkg::CFG_DATA_W'(step), spic_pkg::CFG_DATA_W'(dead),
                   spic_pkg::CFG_DATA_W'(offset), spic_pkg::CFG_DATA_W'(amp_floor),
                   spic_pkg::CFG_DATA_W'(amp_ceiling), spic_pkg::CFG_DATA_W'(lost_ac)};
        for (int r = 0; r < 6; r++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= regs[r];
            cfg_if.data  <= values[r];
            do @(posedge clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
        cfg_phase_step  = step;
        cfg_dead_time   = dead;
        cfg_offset      = offset;
        cfg_amp_floor   = amp_floor;
        cfg_amp_ceiling = amp_ceiling;
        cfg_lost_ac     = lost_ac;
    endtask

    // Fault-free mix: mostly ticks, samples above the lost-AC threshold,
    // a quarter of them repeating the last level
    task automatic send_random_events(input int count);
        int r;
        logic [spic_pkg::SAMPLE_W-1:0] reading;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                send_event(spic_pkg::KIND_TICK, spic_pkg::SAMPLE_W'($urandom));
            end
            else if (r < 90)
            begin
                if ($urandom_range(0, 3) == 0)
                    reading = {prev_level, 3'($urandom)};
                else
                    reading = spic_pkg::SAMPLE_W'($urandom);
                if (reading <= cfg_lost_ac)
                    reading = spic_pkg::SAMPLE_W'($urandom_range(cfg_lost_ac + 1, 1023));
                send_event(spic_pkg::KIND_SAMPLE, reading);
            end
            else
            begin
                send_event(KIND_NOP, spic_pkg::SAMPLE_W'($urandom));
            end
        end
    endtask

    // Any kind, any sample
    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_event(spic_pkg::KIND_W'($urandom_range(0, 3)),
                       spic_pkg::SAMPLE_W'($urandom_range(0, 1023)));
    endtask

    // Reset outputs, first ticks and the regulation clamps at reset settings
    task automatic test_power_on_outputs();
        send_event(KIND_NOP, 10'd0);
        send_event(spic_pkg::KIND_TICK, 10'd0);
        send_event(spic_pkg::KIND_TICK, 10'h3FF);
        send_event(spic_pkg::KIND_SAMPLE, 10'd1023);
        send_event(spic_pkg::KIND_SAMPLE, 10'd40);
        send_event(spic_pkg::KIND_SAMPLE, 10'd47);
        send_event(spic_pkg::KIND_SAMPLE, 10'd33);
        send_event(KIND_NOP, 10'h3FF);
        send_event(spic_pkg::KIND_SAMPLE, 10'd512);
        repeat (4) send_event(spic_pkg::KIND_TICK, 10'd0);
        park_item();
        wait_for_results();
    endtask

    // Run ticks back to back with no gaps, then with random gaps
    task automatic test_tick_burst();
        program_registers(spic_pkg::PHASE_W'($urandom), spic_pkg::DEAD_RESET,
                          spic_pkg::OFFSET_RESET, spic_pkg::AMP_MIN_RESET,
                          spic_pkg::AMP_MAX_RESET, spic_pkg::LOST_AC_RESET);
        no_idle = 1'b1;
        repeat (150) send_event(spic_pkg::KIND_TICK, spic_pkg::SAMPLE_W'($urandom));
        no_idle = 1'b0;
        repeat (150) send_event(spic_pkg::KIND_TICK, spic_pkg::SAMPLE_W'($urandom));
        park_item();
        wait_for_results();
    endtask

    // Sweep register settings, extremes first, with random traffic under each
    task automatic test_register_sweep();
        logic [spic_pkg::AMP_W-1:0] amp_floor;
        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0: program_registers(32'd0, 3'd0, 8'd0, 7'd0, 7'd0, 10'd0);
                1: program_registers(32'hFFFF_FFFF, 3'd7, 8'd255, 7'd100, 7'd100, 10'd0);
                // floor above ceiling, one table step per tick
                2: program_registers(32'h0200_0000, spic_pkg::DEAD_W'($urandom),
                                     spic_pkg::OFFSET_W'($urandom), 7'd100, 7'd0,
                                     spic_pkg::SAMPLE_W'($urandom_range(0, 100)));
                // offset at zero: every nonzero level drives the target negative
                3: program_registers(32'h0200_0000 + $urandom_range(0, 32'h00FF_FFFF),
                                     spic_pkg::DEAD_W'($urandom), 8'd0, 7'd20, 7'd90,
                                     spic_pkg::SAMPLE_W'($urandom_range(0, 300)));
                default:
                begin
                    amp_floor = spic_pkg::AMP_W'($urandom_range(0, 100));
                    program_registers(spic_pkg::PHASE_W'($urandom),
                                      spic_pkg::DEAD_W'($urandom),
                                      spic_pkg::OFFSET_W'($urandom), amp_floor,
                                      spic_pkg::AMP_W'($urandom_range(amp_floor, 100)),
                                      spic_pkg::SAMPLE_W'($urandom_range(0, 400)));
                end
            endcase
            send_random_events(120);
            park_item();
            wait_for_results();
        end
    endtask

    // Stall the result side long enough to back up the core, then pause
    // the sender until every word is back
    task automatic test_backpressure();
        hold_request = 400;
        no_idle = 1'b1;
        send_random_events(30);
        no_idle = 1'b0;
        park_item();
        wait_for_results();
        send_random_events(20);
        park_item();
        wait_for_results();
    endtask

    // Latch one fault: lost AC at the threshold or overload, chosen at random
    task automatic test_fault_latch();
        logic [spic_pkg::SAMPLE_W-1:0] threshold;
        threshold = spic_pkg::SAMPLE_W'($urandom_range(0, 1022));
        program_registers(spic_pkg::PHASE_W'($urandom), spic_pkg::DEAD_W'($urandom),
                          spic_pkg::OFFSET_RESET, spic_pkg::AMP_MIN_RESET,
                          spic_pkg::AMP_MAX_RESET, threshold);
        send_random_events(10);
        if ($urandom_range(0, 1) == 0)
        begin
            // just above, then at the threshold; ticks keep running afterwards
            send_event(spic_pkg::KIND_SAMPLE, threshold + 1'b1);
            send_event(spic_pkg::KIND_SAMPLE, threshold);
            repeat (5) send_event(spic_pkg::KIND_TICK, 10'd0);
            send_event(spic_pkg::KIND_SAMPLE, 10'd1023);
            send_event(spic_pkg::KIND_OVERLOAD, 10'd0);
            repeat (3) send_event(spic_pkg::KIND_TICK, 10'h3FF);
        end
        else
        begin
            // overload freezes the phase and ignores samples
            send_event(spic_pkg::KIND_OVERLOAD, spic_pkg::SAMPLE_W'($urandom));
            repeat (5) send_event(spic_pkg::KIND_TICK, 10'd0);
            send_event(spic_pkg::KIND_SAMPLE, 10'd0);
            send_event(spic_pkg::KIND_SAMPLE, 10'd1023);
        end
        park_item();
        wait_for_results();
        program_registers(spic_pkg::PHASE_W'($urandom), 3'd7, 8'd255, 7'd0, 7'd100,
                          10'h3FF);
        send_noise(150);
        park_item();
        wait_for_results();
    endtask

    initial
    begin
        item_if.valid  <= 1'b0;
        item_if.kind   <= spic_pkg::KIND_TICK;
        item_if.sample <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= spic_pkg::CFG_PHASE_INCREMENT;
        cfg_if.data    <= '0;

        cfg_phase_step  = spic_pkg::PHASE_INC_RESET;
        cfg_dead_time   = spic_pkg::DEAD_RESET;
        cfg_offset      = spic_pkg::OFFSET_RESET;
        cfg_amp_floor   = spic_pkg::AMP_MIN_RESET;
        cfg_amp_ceiling = spic_pkg::AMP_MAX_RESET;
        cfg_lost_ac     = spic_pkg::LOST_AC_RESET;
        phase_acc   = '0;
        blink_count = 0;
        led_on      = 1'b0;
        drive_armed = 1'b1;
        drive_live  = 1'b0;
        leg_one     = 1'b0;
        leg_two     = 1'b0;
        amp_pct     = spic_pkg::AMP_RESET;
        prev_level  = '0;
        fault_now   = spic_pkg::FAULT_NONE;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_power_on_outputs();
        test_tick_burst();
        test_register_sweep();
        test_backpressure();
        test_fault_latch();

        // Let any stray word show up before the verdict
        wait_for_results();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
